FILE: hw/rtl/sseg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_pkg
// Shared constants, segment step table and decimal helpers for the
// seven-segment scanner.
// ----------------------------------------------------------------------------
package sseg_pkg;

    localparam int MAX_DIGITS_DEF = 4;
    localparam int SEGMENT_STEPS  = 7;
    localparam int VALUE_W        = 16;
    localparam int DIGIT_W        = 4;
    localparam int COUNT_W        = 3;
    localparam int SELECT_W       = 4;
    localparam int SEG_W          = 8;
    localparam int STEP_W         = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [SEG_W-1:0]   ALL_OFF     = 8'hFF;
    localparam logic [STEP_W-1:0]  STEP_BLANK  = 3'(SEGMENT_STEPS);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

    // reciprocal of ten, exact for 16-bit operands
    localparam logic [VALUE_W-1:0] RECIP_TEN = 16'd52429;
    localparam int                 RECIP_SH  = 19;

    typedef logic [SEG_W-1:0]   t_seg;
    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_seg SEG_TABLE [10][SEGMENT_STEPS] = '{
        '{8'hDF, 8'hBF, 8'hFB, 8'hF7, 8'hEF, 8'hFE, 8'hFF},
        '{8'hBF, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hDF, 8'hBF, 8'hFD, 8'hEF, 8'hF7, 8'hFF, 8'hFF},
        '{8'hDF, 8'hBF, 8'hFD, 8'hFB, 8'hF7, 8'hFF, 8'hFF},
        '{8'hFE, 8'hFD, 8'hBF, 8'hFB, 8'hFF, 8'hFF, 8'hFF},
        '{8'hDF, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hFF, 8'hFF},
        '{8'hDF, 8'hFB, 8'hF7, 8'hEF, 8'hFE, 8'hFD, 8'hFF},
        '{8'hDF, 8'hBF, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hDF, 8'hBF, 8'hFB, 8'hF7, 8'hEF, 8'hFE, 8'hFD},
        '{8'hDF, 8'hBF, 8'hFB, 8'hF7, 8'hFE, 8'hFD, 8'hFF}
    };

    function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] v);
        logic [2*VALUE_W-1:0] p;
        p = {{VALUE_W{1'b0}}, v} * {{VALUE_W{1'b0}}, RECIP_TEN};
        return VALUE_W'(p >> RECIP_SH);
    endfunction

    function automatic t_digit rem10(input logic [VALUE_W-1:0] v,
                                     input logic [VALUE_W-1:0] q);
        logic [VALUE_W-1:0] r;
        r = v - (q << 3) - (q << 1);
        return DIGIT_W'(r);
    endfunction

    function automatic t_seg seg_lookup(input t_digit d, input logic [STEP_W-1:0] s);
        t_seg res;
        res = ALL_OFF;
        if (d <= DIGIT_MAX && s < STEP_BLANK) begin
            res = SEG_TABLE[d][s];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/sseg_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_digit_split
// Pipelined decimal splitter: one divide-by-ten per stage, stallable,
// a beat may enter every cycle.
// ----------------------------------------------------------------------------
module sseg_digit_split #(
    parameter int MAX_DIGITS = sseg_pkg::MAX_DIGITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [sseg_pkg::VALUE_W-1:0]          i_value,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output logic [MAX_DIGITS-1:0][sseg_pkg::DIGIT_W-1:0] o_digits,
    input  logic                                  i_take
);
    import sseg_pkg::*;

    logic                                   r_vld [MAX_DIGITS];
    logic [VALUE_W-1:0]                     r_rem [MAX_DIGITS];
    logic [VALUE_W-1:0]                     r_quo [MAX_DIGITS];
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]     r_dig [MAX_DIGITS];
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]     n_dig [MAX_DIGITS];
    logic [MAX_DIGITS-1:0]                  adv;

    always_comb begin
        adv[MAX_DIGITS-1] = !r_vld[MAX_DIGITS-1] || i_take;
        for (int j = MAX_DIGITS - 2; j >= 0; j--) begin
            adv[j] = !r_vld[j] || adv[j+1];
        end
    end

    always_comb begin
        n_dig[0] = '0;
        for (int j = 1; j < MAX_DIGITS; j++) begin
            n_dig[j]      = r_dig[j-1];
            n_dig[j][j-1] = rem10(r_rem[j-1], r_quo[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_DIGITS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j < MAX_DIGITS; j++) begin
                if (adv[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_rem[0] <= i_value;
            r_quo[0] <= div10(i_value);
            r_dig[0] <= n_dig[0];
        end
        for (int j = 1; j < MAX_DIGITS; j++) begin
            if (adv[j]) begin
                r_rem[j] <= r_quo[j-1];
                r_quo[j] <= div10(r_quo[j-1]);
                r_dig[j] <= n_dig[j];
            end
        end
    end

    always_comb begin
        o_digits               = r_dig[MAX_DIGITS-1];
        o_digits[MAX_DIGITS-1] = rem10(r_rem[MAX_DIGITS-1], r_quo[MAX_DIGITS-1]);
    end

    assign o_valid = r_vld[MAX_DIGITS-1];
    assign o_ready = adv[0];

endmodule

FILE: hw/rtl/seven_segment_segment_scan_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_segment_scan_top
// Splits a 16-bit value into decimal digits and scans them out to a
// multiplexed seven-segment display, eight active-low steps per display.
// Scanning: one step a cycle; runs follow each other with no gap, the
//   splitter pipeline takes new values while a run is being scanned.
// Reset: synchronous active-low; clears all valid bits and the scanner,
//   display_count returns to 4. The receiver cannot stall the strobe.
// ----------------------------------------------------------------------------
module seven_segment_segment_scan_top #(
    parameter int MAX_DIGITS = sseg_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sseg_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_cfg_we,
    input  logic [sseg_pkg::COUNT_W-1:0]    i_cfg_wdata,
    output logic                            o_strobe,
    output logic [sseg_pkg::SELECT_W-1:0]   o_digit_select,
    output logic [sseg_pkg::SEG_W-1:0]      o_segment_pattern,
    output logic                            o_last_of_run
);
    import sseg_pkg::*;

    localparam int DISP_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DIGITS);

    logic [COUNT_W-1:0]                 r_display_count;
    logic                               split_ready;
    logic                               split_valid;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] split_digits;
    logic                               load;

    logic                               r_active, n_active;
    logic [DISP_W-1:0]                  r_disp, n_disp;
    logic [STEP_W-1:0]                  r_step, n_step;
    logic [COUNT_W-1:0]                 r_count, n_count;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] r_digits, n_digits;

    logic                               r_strobe;
    logic [SELECT_W-1:0]                r_sel;
    logic [SEG_W-1:0]                   r_seg;
    logic                               r_last;

    logic [COUNT_W-1:0]                 eff_count;
    logic                               run_end;
    logic                               disp_end;
    logic [SELECT_W-1:0]                cur_sel;
    logic [SEG_W-1:0]                   cur_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_display_count <= i_cfg_wdata;
        end
    end

    sseg_digit_split #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_value  (i_value),
        .o_ready  (split_ready),
        .o_valid  (split_valid),
        .o_digits (split_digits),
        .i_take   (load)
    );

    assign busy = !split_ready;

    assign eff_count = (r_display_count > COUNT_MAX) ? COUNT_MAX : r_display_count;
    assign disp_end  = (r_step == STEP_BLANK);
    assign run_end   = disp_end && (r_disp == DISP_W'(r_count - 3'd1));
    assign load      = split_valid && (!r_active || run_end);

    assign cur_sel = SELECT_W'(~(4'b0001 << r_disp));
    assign cur_seg = disp_end ? ALL_OFF : seg_lookup(r_digits[r_disp], r_step);

    always_comb begin
        n_active = r_active;
        n_disp   = r_disp;
        n_step   = r_step;
        n_count  = r_count;
        n_digits = r_digits;
        if (load) begin
            // a count of zero swallows the beat with no steps
            n_active = (eff_count != '0);
            n_disp   = '0;
            n_step   = '0;
            n_count  = eff_count;
            n_digits = split_digits;
        end else if (r_active) begin
            if (run_end) begin
                n_active = 1'b0;
            end else if (disp_end) begin
                n_step = '0;
                n_disp = r_disp + 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disp   <= n_disp;
        r_step   <= n_step;
        r_count  <= n_count;
        r_digits <= n_digits;
        r_sel    <= cur_sel;
        r_seg    <= cur_seg;
        r_last   <= run_end;
    end

    assign o_strobe          = r_strobe;
    assign o_digit_select    = r_sel;
    assign o_segment_pattern = r_seg;
    assign o_last_of_run     = r_last;

    a_sel_one_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot(~o_digit_select))
        else $error("digit select not one-cold");

    a_last_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_run) |-> (o_segment_pattern == ALL_OFF))
        else $error("end of run on a non-blank step");

    a_run_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && run_end) |=> (o_strobe && o_last_of_run))
        else $error("run end not flagged");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule
